/* sv/buddy_page_allocator_assert.svh */
// Assertion macros for the buddy page allocator checker.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Constants and helpers shared by the buddy page allocator files.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
  localparam int MaxPages    = 16384;
  localparam int NumClasses  = 11;
  localparam int PageShift   = 12;
  localparam int TopClass    = NumClasses - 1;
  localparam int TopSize     = 1 << TopClass;
  localparam int StoreSize   = 2 * MaxPages;
  localparam int AddrW       = $clog2(StoreSize);
  localparam int PageW       = $clog2(MaxPages);
  localparam int DepthW      = PageW + 1;
  localparam int ClassW      = 4;

  localparam logic [1:0] CmdAlloc  = 2'd0;
  localparam logic [1:0] CmdAlloc1 = 2'd1;
  localparam logic [1:0] CmdInit   = 2'd2;

  localparam logic [0:0] RegBase  = 1'b0;
  localparam logic [0:0] RegTotal = 1'b1;

  // Base address of class k inside the shared stack memory.
  function automatic logic [AddrW-1:0] class_offset(input logic [ClassW-1:0] k);
    logic [AddrW:0] s;
    s = (AddrW+1)'(StoreSize);
    return AddrW'(s - (s >> k));
  endfunction

  function automatic logic [DepthW-1:0] class_capacity(input logic [ClassW-1:0] k);
    return DepthW'(MaxPages) >> k;
  endfunction
endpackage
`default_nettype wire

/* sv/buddy_page_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator: 11 size classes held as LIFO stacks, plus a pool.
// ----------------------------------------------------------------------------
// One command is handled at a time; the result waits in an output register
// and the next command is taken in the cycle after that result is handed
// over. A pool allocation, a rejected count or an unused command has its
// result registered in the cycle after acceptance.
// A buddy allocation checks class depths upward from the wanted class, one a
// cycle, then reads the stack top in the StRd and StRdW states and splits in
// StSplit, one level at a time, down to the wanted class. A search that finds
// every class from the wanted one up empty fails. Init writes 12 + n stack
// entries one per cycle (n top-class blocks from page 2048) and then sets up
// the pool.
`default_nettype none
module buddy_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [11:0] req_pages,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic [31:0]      block_addr,
  output logic [3:0]       size_class
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSrch  = 3'd1;
  localparam logic [2:0] StRd    = 3'd2;
  localparam logic [2:0] StRdW   = 3'd3;
  localparam logic [2:0] StSplit = 3'd4;
  localparam logic [2:0] StInit  = 3'd5;

  localparam int AW = bpa_pkg::AddrW;
  localparam int PW = bpa_pkg::PageW;
  localparam int DW = bpa_pkg::DepthW;
  localparam int CW = bpa_pkg::ClassW;

  logic [19:0]   page_base_frame;
  logic [14:0]   total_pages;
  logic [2:0]    state;
  logic [DW-1:0] depth [bpa_pkg::NumClasses];
  logic [DW-1:0] pool_top, pool_base;
  logic [CW-1:0] want, ph;
  logic [PW-1:0] page;
  logic [DW-1:0] init_p;
  logic [CW-1:0] init_k;
  logic          init_first;

  logic [PW-1:0] mem [bpa_pkg::StoreSize];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [PW-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  logic          accept;
  logic [CW-1:0] want_calc;
  logic [DW-1:0] total_sat;
  logic [CW-1:0] ph_m1;
  logic [DW-1:0] tgt_depth;

  assign in_stall = (state != StIdle) || out_valid;
  assign accept   = in_valid && !in_stall;

  // ceil(log2(count)) for 1..1024
  always_comb begin
    want_calc = '0;
    for (int i = bpa_pkg::TopClass; i >= 1; i--)
      if ({1'b0, req_pages - 12'd1} >= 13'(1 << (i - 1))) begin
        if (want_calc == '0) want_calc = CW'(i);
      end
  end

  assign total_sat = (total_pages > 15'(bpa_pkg::MaxPages)) ?
                     DW'(bpa_pkg::MaxPages) : DW'(total_pages);
  assign ph_m1     = ph - CW'(1);
  assign tgt_depth = depth[ph_m1];

  function automatic logic [31:0] addr_of(input logic [19:0] f, input logic [PW-1:0] p);
    return {f, 12'd0} + (32'(p) << bpa_pkg::PageShift);
  endfunction

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = bpa_pkg::class_offset(ph) + AW'(depth[ph] - DW'(1));
    case (state)
      StSplit: begin
        mem_we    = (tgt_depth < bpa_pkg::class_capacity(ph_m1));
        mem_waddr = bpa_pkg::class_offset(ph_m1) + AW'(tgt_depth);
        mem_wdata = page + PW'(1 << ph_m1);
      end
      StInit: begin
        if (init_first) begin
          mem_we    = 1'b1;
          mem_waddr = bpa_pkg::class_offset(init_k) + AW'(depth[init_k]);
          mem_wdata = (init_k == '0) ? PW'(depth[0]) : PW'(1 << init_k);
        end else if (init_p + DW'(bpa_pkg::TopSize) < total_sat) begin
          mem_we    = depth[bpa_pkg::TopClass] < bpa_pkg::class_capacity(CW'(bpa_pkg::TopClass));
          mem_waddr = bpa_pkg::class_offset(CW'(bpa_pkg::TopClass)) +
                      AW'(depth[bpa_pkg::TopClass]);
          mem_wdata = PW'(init_p);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        bpa_pkg::RegBase:  page_base_frame <= cfg_data;
        bpa_pkg::RegTotal: total_pages     <= cfg_data[14:0];
        default: ;
      endcase
    end
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
      pool_top  <= '0;
      pool_base <= '0;
      page_base_frame <= 20'd256;
      total_pages     <= 15'd16384;
      for (int i = 0; i < bpa_pkg::NumClasses; i++) depth[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        StIdle: if (accept) begin
          if (cmd == bpa_pkg::CmdInit) begin
            for (int i = 0; i < bpa_pkg::NumClasses; i++) depth[i] <= '0;
            init_first <= 1'b1;
            init_k     <= '0;
            init_p     <= DW'(2 * bpa_pkg::TopSize);
            state      <= StInit;
          end else if (cmd == bpa_pkg::CmdAlloc1 && pool_top > pool_base) begin
            pool_top   <= pool_top - DW'(1);
            ok         <= 1'b1;
            block_addr <= addr_of(page_base_frame, PW'(pool_top - DW'(1)));
            size_class <= '0;
            out_valid  <= 1'b1;
          end else if (cmd == bpa_pkg::CmdAlloc1 ||
                       (cmd == bpa_pkg::CmdAlloc && req_pages != 12'd0 &&
                        req_pages <= 12'(bpa_pkg::TopSize))) begin
            want  <= (cmd == bpa_pkg::CmdAlloc1) ? '0 : want_calc;
            ph    <= (cmd == bpa_pkg::CmdAlloc1) ? '0 : want_calc;
            state <= StSrch;
          end else begin
            ok <= 1'b0; block_addr <= '0;
            size_class <= CW'(bpa_pkg::NumClasses);
            out_valid <= 1'b1;
          end
        end
        StSrch: begin
          if (depth[ph] != '0) state <= StRd;
          else if (ph == CW'(bpa_pkg::TopClass)) begin
            ok <= 1'b0; block_addr <= '0;
            size_class <= CW'(bpa_pkg::NumClasses);
            out_valid <= 1'b1;
            state <= StIdle;
          end else ph <= ph + CW'(1);
        end
        StRd: begin
          depth[ph] <= depth[ph] - DW'(1);
          state     <= StRdW;
        end
        StRdW: begin
          page  <= mem_rdata;
          state <= StSplit;
        end
        StSplit: begin
          if (ph == want) begin
            ok <= 1'b1;
            block_addr <= addr_of(page_base_frame, page);
            size_class <= want;
            out_valid <= 1'b1;
            state <= StIdle;
          end else begin
            if (mem_we) depth[ph_m1] <= tgt_depth + DW'(1);
            ph <= ph_m1;
          end
        end
        StInit: begin
          if (init_first) begin
            depth[init_k] <= depth[init_k] + DW'(1);
            if (init_k == '0 && depth[0] == '0) init_k <= '0;
            else if (init_k == CW'(bpa_pkg::TopClass)) init_first <= 1'b0;
            else init_k <= init_k + CW'(1);
          end else if (init_p + DW'(bpa_pkg::TopSize) < total_sat) begin
            if (mem_we) depth[bpa_pkg::TopClass] <= depth[bpa_pkg::TopClass] + DW'(1);
            init_p <= init_p + DW'(bpa_pkg::TopSize);
          end else begin
            pool_base <= init_p;
            pool_top  <= (total_sat > init_p) ? total_sat : init_p;
            ok <= 1'b1; block_addr <= '0; size_class <= '0;
            out_valid <= 1'b1;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/bpa_checker.sv */
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the buddy page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_page_allocator_assert.svh"
module bpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        ok,
  input wire logic [31:0] block_addr,
  input wire logic [3:0]  size_class
);
  localparam logic [3:0] FailClass = 4'(bpa_pkg::NumClasses);
  localparam logic [3:0] TopClass  = 4'(bpa_pkg::TopClass);

  logic fail_coded;
  logic stalled;
  assign fail_coded = (size_class == FailClass) && (block_addr == 32'd0);
  assign stalled    = out_valid && out_stall;

  `BPA_ASSERT_IMPL(a_fail_code, clk, rst, out_valid && !ok, fail_coded, "bad failure code")
  `BPA_ASSERT_IMPL(a_ok_class, clk, rst, out_valid && ok, size_class <= TopClass, "bad class")
  `BPA_ASSERT_IMPL(a_busy_out, clk, rst, out_valid, in_stall, "input taken while result waits")
  `BPA_ASSERT_NEXT(a_hold, clk, rst, stalled, out_valid && $stable(block_addr), "result changed")
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
`default_nettype wire
